@@ hw/rtl/tte_pkg.sv @@
// Shared types, constants and the phase-interpolation ROMs for the time-tag event decoder.
// No dependencies; imported by every module of the block.
package tte_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_MODE      = 3'd0,
    REG_MARK_MODE      = 3'd1,
    REG_TRAP_ENABLE    = 3'd2,
    REG_PATTERN_SELECT = 3'd3,
    REG_SKIP_COUNT     = 3'd4,
    REG_MAX_EVENTS     = 3'd5
  } cfg_reg_e;

  // Mark source codes
  typedef enum logic [1:0] {
    MARK_PHASE  = 2'd0,
    MARK_REJECT = 2'd1,
    MARK_ZERO   = 2'd2,
    MARK_ZERO_B = 2'd3
  } mark_mode_e;

  // Phase ROM codes
  typedef enum logic [1:0] {
    PAT_DEFAULT = 2'd0,
    PAT_REV1    = 2'd1,
    PAT_REV2    = 2'd2,
    PAT_NONE    = 2'd3
  } pattern_e;

  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned CfgDataW    = 31;
  localparam int unsigned QueueDepth  = 2;
  // Fast-counter field value below which the pipeline carry fix applies
  localparam logic [4:0]  CarryFixLim = 5'd17;
  localparam logic [10:0] WarmLimit   = 11'd1024;
  localparam logic [10:0] WarmSat     = 11'd1025;

  // Static configuration seen by front and back
  typedef struct packed {
    logic       time_mode;
    mark_mode_e mark_mode;
    logic       trap_enable;
    pattern_e   pattern_select;
    logic [30:0] max_events;
  } cfg_t;

  // Item handed from front to back
  typedef struct packed {
    logic        mismatch;   // coarse time out of window
    logic [63:0] sum;        // timestamp after carry fix and offset, marks not yet added
    logic [8:0]  phase_pat;  // raw phase pattern, used as mark in mode 0
    logic [22:0] uval;       // carry-fixed coarse word >> 9 for the trap filter
  } entry_t;

  // Phase-interpolation ROM lookup
  function automatic logic [3:0] phase_lookup(input pattern_e sel, input logic [8:0] pat);
    logic [3:0] v;
    v = 4'd0;
    case (sel)
      PAT_DEFAULT: begin
        case (pat)
          9'd6:   v = 4'd4;
          9'd7:   v = 4'd5;
          9'd12:  v = 4'd3;
          9'd14:  v = 4'd7;
          9'd39:  v = 4'd4;
          9'd136: v = 4'd5;
          9'd140: v = 4'd7;
          9'd142: v = 4'd5;
          9'd152: v = 4'd8;
          9'd156: v = 4'd11;
          9'd216: v = 4'd9;
          9'd295: v = 4'd2;
          9'd359: v = 4'd1;
          9'd371: v = 4'd15;
          9'd375: v = 4'd1;
          9'd472: v = 4'd10;
          9'd497: v = 4'd14;
          9'd499: v = 4'd14;
          9'd504: v = 4'd12;
          9'd505: v = 4'd13;
          9'd507: v = 4'd11;
          default: v = 4'd0;
        endcase
      end
      PAT_REV1: begin
        case (pat)
          9'd6:   v = 4'd6;
          9'd7:   v = 4'd5;
          9'd14:  v = 4'd6;
          9'd39:  v = 4'd4;
          9'd140: v = 4'd5;
          9'd152: v = 4'd7;
          9'd156: v = 4'd5;
          9'd216: v = 4'd7;
          9'd295: v = 4'd1;
          9'd359: v = 4'd0;
          9'd371: v = 4'd0;
          9'd375: v = 4'd3;
          9'd472: v = 4'd8;
          9'd497: v = 4'd15;
          9'd499: v = 4'd15;
          9'd504: v = 4'd11;
          9'd505: v = 4'd13;
          9'd507: v = 4'd14;
          default: v = 4'd0;
        endcase
      end
      PAT_REV2: begin
        case (pat)
          9'd6:   v = 4'd5;
          9'd7:   v = 4'd4;
          9'd12:  v = 4'd6;
          9'd14:  v = 4'd5;
          9'd39:  v = 4'd3;
          9'd136: v = 4'd6;
          9'd140: v = 4'd6;
          9'd142: v = 4'd6;
          9'd152: v = 4'd7;
          9'd156: v = 4'd7;
          9'd216: v = 4'd8;
          9'd295: v = 4'd2;
          9'd359: v = 4'd1;
          9'd371: v = 4'd14;
          9'd375: v = 4'd0;
          9'd472: v = 4'd9;
          9'd497: v = 4'd13;
          9'd499: v = 4'd13;
          9'd504: v = 4'd11;
          9'd505: v = 4'd12;
          9'd507: v = 4'd13;
          default: v = 4'd0;
        endcase
      end
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/tte_front.sv @@
// Front end: accepts items, owns the offset table, checks the coarse window and
// rebuilds the timestamp up to the mark bits. Depends on tte_pkg.
module tte_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tte_pkg::cfg_t    cfg_i,
  input  logic             accept_i,
  input  logic             kind_i,
  input  logic [31:0]      fine_word_i,
  input  logic [31:0]      coarse_word_i,
  input  logic [15:0]      ref_coarse_i,
  input  logic [3:0]       offset_index_i,
  input  logic [63:0]      offset_value_i,
  output logic             push_o,
  output tte_pkg::entry_t  entry_o
);
  import tte_pkg::*;

  logic [63:0] offset_q [16];
  logic [31:0] cvd;
  logic [3:0]  lines;
  logic [3:0]  phase;
  logic [39:0] top_inc;
  logic [39:0] top_fix;
  logic [31:0] dv0;
  logic [31:0] cv_fix;
  logic [31:0] dv_fix;
  logic [63:0] off;

  // Offset table, written in item order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        offset_q[i] <= '0;
      end
    end else if (accept_i && kind_i) begin
      offset_q[offset_index_i] <= offset_value_i;
    end
  end

  // Coarse window check
  assign cvd = {16'd0, coarse_word_i[31:16]} - {16'd0, ref_coarse_i} + 32'd2;

  // Field assembly; mark bits stay zero here
  assign lines = {fine_word_i[15:14], fine_word_i[17:16]};
  assign phase = phase_lookup(cfg_i.pattern_select, fine_word_i[8:0]);
  assign dv0   = {fine_word_i[31:24], fine_word_i[13:9], phase, 11'd0, lines};

  // Pipeline carry fix: bump the counter byte, carry into the coarse word
  assign top_inc = {coarse_word_i, dv0[31:24]} + 40'd1;
  assign top_fix = (fine_word_i[13:9] < CarryFixLim) ? top_inc
                                                     : {coarse_word_i, dv0[31:24]};
  assign cv_fix  = top_fix[39:8];
  assign dv_fix  = {top_fix[7:0], dv0[23:0]};

  // Optional per-detector offset
  assign off = cfg_i.time_mode ? offset_q[lines] : 64'd0;

  always_comb begin
    entry_o.mismatch  = (cvd > 32'd4);
    entry_o.sum       = {cv_fix, dv_fix} + off;
    entry_o.phase_pat = fine_word_i[8:0];
    entry_o.uval      = cv_fix[31:9];
  end

  assign push_o = accept_i && !kind_i;

endmodule

@@ hw/rtl/tte_queue.sv @@
// Short queue between front and back so that each side stalls on its own.
// Depends on tte_pkg for the item type and depth.
module tte_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tte_pkg::entry_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tte_pkg::entry_t  data_o
);
  import tte_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/tte_back.sv @@
// Back end: stop, reject counting, mark bits, trap filter, skip and event count,
// plus the output register. Depends on tte_pkg.
module tte_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tte_pkg::cfg_t    cfg_i,
  input  logic             skip_load_i,
  input  logic [30:0]      skip_value_i,
  input  logic             valid_i,
  input  tte_pkg::entry_t  entry_i,
  output logic             take_o,
  output logic             res_valid_o,
  input  logic             res_pop_i,
  output logic [31:0]      time_high_o,
  output logic [31:0]      time_low_o,
  output logic             finished_o
);
  import tte_pkg::*;

  logic [22:0] prev_q, prev_d;
  logic [31:0] avg_q, avg_d;
  logic [10:0] warm_q, warm_d;
  logic [30:0] cnt_q, cnt_d;
  logic [30:0] skip_q, skip_d;
  logic [8:0]  rej_q, rej_d;
  logic        stop_q, stop_d;
  logic        res_valid_q, res_valid_d;
  logic [63:0] res_q, res_d;
  logic        fin_q, fin_d;

  logic        fire;
  logic [8:0]  mark;
  logic [63:0] stamp;
  logic signed [23:0] diff;
  logic [31:0] diff_w;
  logic [31:0] diff_x32;
  logic [31:0] avg_div;
  logic [31:0] avg_new;
  logic        trap_drop;
  logic [30:0] cnt_inc;

  // Process the queue head when the output slot is free or frees this cycle
  assign fire   = valid_i && (!res_valid_q || res_pop_i);
  assign take_o = fire;

  // Mark bits and final timestamp
  always_comb begin
    case (cfg_i.mark_mode)
      MARK_PHASE:  mark = entry_i.phase_pat;
      MARK_REJECT: mark = rej_q;
      default:     mark = 9'd0;
    endcase
  end
  assign stamp = entry_i.sum + {51'd0, mark, 4'd0};

  // Trap filter arithmetic
  assign diff     = $signed({1'b0, entry_i.uval}) - $signed({1'b0, prev_q});
  assign diff_w   = {{8{diff[23]}}, diff};
  assign diff_x32 = diff_w << 5;
  assign avg_div  = 32'($signed(avg_q + (avg_q[31] ? 32'd255 : 32'd0)) >>> 8);
  assign avg_new  = avg_q + diff_w - avg_div;
  assign trap_drop = (warm_q > WarmLimit) &&
                     (diff[23] || ($signed(diff_x32) > $signed(avg_q)));
  assign cnt_inc  = cnt_q + 31'd1;

  // Per-item state update
  always_comb begin
    logic keep;
    logic fin;
    keep        = 1'b1;
    fin         = 1'b0;
    prev_d      = prev_q;
    avg_d       = avg_q;
    warm_d      = warm_q;
    cnt_d       = cnt_q;
    skip_d      = skip_q;
    rej_d       = rej_q;
    stop_d      = stop_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_d       = res_q;
    fin_d       = fin_q;
    if (skip_load_i) begin
      skip_d = skip_value_i;
    end
    if (fire && !stop_q) begin
      if (entry_i.mismatch) begin
        if (cfg_i.mark_mode == MARK_REJECT) begin
          rej_d = rej_q + 9'd1;
        end
      end else begin
        if (cfg_i.trap_enable) begin
          prev_d = entry_i.uval;
          if (trap_drop) begin
            keep = 1'b0;
          end else begin
            avg_d = avg_new;
          end
          if (warm_q < WarmSat) begin
            warm_d = warm_q + 11'd1;
          end
        end
        if (keep && (skip_q != '0)) begin
          skip_d = skip_q - 31'd1;
          keep   = 1'b0;
        end
        if (cfg_i.max_events != '0) begin
          cnt_d = cnt_inc;
          if (cnt_inc == cfg_i.max_events) begin
            stop_d = 1'b1;
            fin    = 1'b1;
          end
        end
        if (keep || fin) begin
          res_valid_d = 1'b1;
          res_d       = keep ? stamp : 64'd0;
          fin_d       = fin;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      avg_q       <= '0;
      warm_q      <= '0;
      cnt_q       <= '0;
      skip_q      <= '0;
      rej_q       <= '0;
      stop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      avg_q       <= avg_d;
      warm_q      <= warm_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      rej_q       <= rej_d;
      stop_q      <= stop_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    fin_q <= fin_d;
  end

  assign res_valid_o = res_valid_q;
  assign time_high_o = res_q[63:32];
  assign time_low_o  = res_q[31:0];
  assign finished_o  = fin_q;

endmodule

@@ hw/rtl/timetag_event_decoder.sv @@
// Time-tag event decoder top level: configuration registers, front end, queue, back end.
// Depends on tte_pkg, tte_front, tte_queue and tte_back.
// Throughput: one item per cycle while the queue has room and results are popped; an
// item passes the queue, then the back end's output register. The two-entry queue and
// the one-entry output register set the buffering. Reset clears configuration to
// defaults (pattern_select 2), zeroes the offset table, trap filter, counters and queue.
module timetag_event_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [31:0] fine_word_i,
  input  logic [31:0] coarse_word_i,
  input  logic [15:0] ref_coarse_i,
  input  logic [3:0]  offset_index_i,
  input  logic [63:0] offset_value_i,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [31:0] time_high_o,
  output logic [31:0] time_low_o,
  output logic        finished_o,
  // configuration writes
  input  logic        wr_en_i,
  input  logic [2:0]  wr_index_i,
  input  logic [30:0] wr_data_i
);
  import tte_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   skip_load;
  logic   accept;
  logic   q_push, q_full, q_valid, q_take;
  entry_t q_in, q_out;
  logic   res_valid;

  // Configuration registers
  always_comb begin
    cfg_d     = cfg_q;
    skip_load = 1'b0;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_TIME_MODE:      cfg_d.time_mode      = wr_data_i[0];
        REG_MARK_MODE:      cfg_d.mark_mode      = mark_mode_e'(wr_data_i[1:0]);
        REG_TRAP_ENABLE:    cfg_d.trap_enable    = wr_data_i[0];
        REG_PATTERN_SELECT: cfg_d.pattern_select = pattern_e'(wr_data_i[1:0]);
        REG_SKIP_COUNT:     skip_load            = 1'b1;
        REG_MAX_EVENTS:     cfg_d.max_events     = wr_data_i;
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_mode      <= 1'b0;
      cfg_q.mark_mode      <= MARK_PHASE;
      cfg_q.trap_enable    <= 1'b0;
      cfg_q.pattern_select <= PAT_REV2;
      cfg_q.max_events     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  tte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .kind_i         (kind_i),
    .fine_word_i    (fine_word_i),
    .coarse_word_i  (coarse_word_i),
    .ref_coarse_i   (ref_coarse_i),
    .offset_index_i (offset_index_i),
    .offset_value_i (offset_value_i),
    .push_o         (q_push),
    .entry_o        (q_in)
  );

  tte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_take),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  tte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .skip_load_i  (skip_load),
    .skip_value_i (wr_data_i),
    .valid_i      (q_valid),
    .entry_i      (q_out),
    .take_o       (q_take),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .time_high_o  (time_high_o),
    .time_low_o   (time_low_o),
    .finished_o   (finished_o)
  );

  assign empty = !res_valid;

endmodule
